// File: hdl/all_pairs_shortest_path_core_assert.svh
// ----------------------------------------------------------------------------
// All-pairs shortest path core assertion macros
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Field widths, the unreachable distance and the action codes of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

  localparam int unsigned DIST_W   = 30;
  localparam int unsigned VERTEX_W = 8;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [DIST_W-1:0]  DIST_INF    = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

endpackage

`default_nettype wire

// File: hdl/all_pairs_shortest_path_core.sv
// ----------------------------------------------------------------------------
// All-pairs shortest path core: reads and writes are taken one item per cycle while
// busy is low, with the read result in the cycle after its transfer. Clear and compute
// hold busy high; compute makes one relaxation per cycle in its column sweep through
// the two read ports of the matrix memory. After reset an initialization pass over all
// MAX_VERTICES*MAX_VERTICES entries runs with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

// The distance matrix lives in one memory with two registered read ports and one
// write port. The address of an entry is the row index concatenated with the
// column index, so rows are padded up to a power of two.
//
// Compute walks k, then row i, then column j. For each row the entry (i,k) is
// read once and held; the columns then stream through both read ports, reading
// (k,j) and (i,j) together, and the compare and write-back of column j happen in
// the cycle that issues the reads of column j+1. A write to row i never meets a
// read of the same entry in one cycle. When i equals k the row being read is the
// row being written, but with non-negative weights such a relaxation can never
// lower an entry, so no write occurs there and stale data cannot matter.

module all_pairs_shortest_path_core
  import apsp_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration write channel: the vertex count register.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [COUNT_W-1:0]  cfg_data_i,

  // Command channel.
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [VERTEX_W-1:0] source_vertex_i,
  input  wire logic [VERTEX_W-1:0] target_vertex_i,
  input  wire logic [DIST_W-1:0]   edge_weight_i,

  // Result channel: one strobed cycle per read.
  output logic                     result_valid_o,
  output logic [DIST_W-1:0]        distance_o
);

  // Index width of one row or column, and a counter width that also holds n.
  localparam int unsigned IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [31:0]   MAX32 = 32'(MAX_VERTICES);
  localparam logic [CW-1:0] MAXN  = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] ONE   = CW'(1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ROW,
    S_IK,
    S_SWEEP
  } state_e;

  state_e          state_q, state_d;
  logic [COUNT_W-1:0] vertex_count_q, vertex_count_d;
  logic [CW-1:0]   lim_q, lim_d;     // n latched for the running sweep
  logic [CW-1:0]   row_q, row_d;     // row i of clear and compute
  logic [CW-1:0]   col_q, col_d;     // column of clear, issued column of compute
  logic [CW-1:0]   k_q, k_d;         // pivot vertex of compute
  logic [IW-1:0]   pcol_q, pcol_d;   // column whose reads are now in rd_*_q
  logic [DIST_W-1:0] ik_q, ik_d;     // held entry (i,k) of the current row
  logic            rd_pend_q, rd_pend_d;
  logic            rd_ok_q, rd_ok_d;

  // Matrix memory and its ports.
  logic [DIST_W-1:0] matrix_mem [DEPTH];
  logic [DIST_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]     addr_a, addr_b, mem_wa;
  logic [DIST_W-1:0] mem_wd;
  logic              mem_we;

  logic              accept;
  logic [31:0]       vc32, src32, dst32, n32;
  logic [CW-1:0]     n_cfg;
  logic [DIST_W:0]   relax_sum;
  logic [CW-1:0]     row_nx, col_nx, k_nx;

  // The configured count saturates at the matrix size.
  assign vc32  = 32'(vertex_count_q);
  assign n_cfg = (vc32 > MAX32) ? MAXN : vc32[CW-1:0];
  assign n32   = 32'(n_cfg);
  assign src32 = 32'(source_vertex_i);
  assign dst32 = 32'(target_vertex_i);

  assign accept = start_i && (state_q == S_IDLE);
  assign row_nx = row_q + ONE;
  assign col_nx = col_q + ONE;
  assign k_nx   = k_q + ONE;

  // The sum through k is one bit wider so that it can never wrap.
  assign relax_sum = {1'b0, ik_q} + {1'b0, rd_a_q};

  always_comb begin
    state_d        = state_q;
    vertex_count_d = vertex_count_q;
    lim_d          = lim_q;
    row_d          = row_q;
    col_d          = col_q;
    k_d            = k_q;
    pcol_d         = pcol_q;
    ik_d           = ik_q;
    rd_pend_d      = 1'b0;
    rd_ok_d        = rd_ok_q;
    mem_we         = 1'b0;
    mem_wa         = {row_q[IW-1:0], col_q[IW-1:0]};
    mem_wd         = DIST_INF;
    addr_a         = {row_q[IW-1:0], k_q[IW-1:0]};
    addr_b         = {src32[IW-1:0], dst32[IW-1:0]};

    // A configuration transfer is taken whenever it is offered.
    if (cfg_valid_i) begin
      vertex_count_d = cfg_data_i;
    end

    case (state_q)
      // Initialization after reset and the clear action share one sweep that
      // writes zero on the diagonal and INF elsewhere, one entry per cycle.
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = (row_q == col_q) ? '0 : DIST_INF;
        if (col_nx == lim_q) begin
          col_d = '0;
          if (row_nx == lim_q) begin
            row_d   = '0;
            state_d = S_IDLE;
          end else begin
            row_d = row_nx;
          end
        end else begin
          col_d = col_nx;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_CLEAR: begin
              lim_d = n_cfg;
              row_d = '0;
              col_d = '0;
              if (n_cfg != '0) begin
                state_d = S_CLEAR;
              end
            end
            ACT_WRITE: begin
              // Writes beyond the matrix are dropped; writes beyond n are kept.
              if ((src32 < MAX32) && (dst32 < MAX32)) begin
                mem_we = 1'b1;
                mem_wa = {src32[IW-1:0], dst32[IW-1:0]};
                mem_wd = edge_weight_i;
              end
            end
            ACT_COMPUTE: begin
              lim_d = n_cfg;
              row_d = '0;
              k_d   = '0;
              if (n_cfg != '0) begin
                state_d = S_ROW;
              end
            end
            ACT_READ: begin
              // The entry is read through port B in this cycle; an index outside
              // the active square turns the result into INF.
              rd_pend_d = 1'b1;
              rd_ok_d   = (src32 < n32) && (dst32 < n32);
            end
            default: begin
            end
          endcase
        end
      end

      // Fetch (i,k) for the new row.
      S_ROW: begin
        state_d = S_IK;
      end

      // Hold (i,k) and issue the first column.
      S_IK: begin
        ik_d    = rd_a_q;
        addr_a  = {k_q[IW-1:0], {IW{1'b0}}};
        addr_b  = {row_q[IW-1:0], {IW{1'b0}}};
        pcol_d  = '0;
        col_d   = ONE;
        state_d = S_SWEEP;
      end

      // Relax the column read last cycle and issue the next one.
      S_SWEEP: begin
        mem_wa = {row_q[IW-1:0], pcol_q};
        mem_wd = relax_sum[DIST_W-1:0];
        mem_we = (relax_sum < {1'b0, rd_b_q});
        if (col_q < lim_q) begin
          addr_a = {k_q[IW-1:0], col_q[IW-1:0]};
          addr_b = {row_q[IW-1:0], col_q[IW-1:0]};
          pcol_d = col_q[IW-1:0];
          col_d  = col_nx;
        end else begin
          state_d = S_ROW;
          if (row_nx == lim_q) begin
            row_d = '0;
            if (k_nx == lim_q) begin
              k_d     = '0;
              state_d = S_IDLE;
            end else begin
              k_d = k_nx;
            end
          end else begin
            row_d = row_nx;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      vertex_count_q <= COUNT_RESET;
      lim_q          <= MAXN;
      row_q          <= '0;
      col_q          <= '0;
      k_q            <= '0;
      pcol_q         <= '0;
      rd_pend_q      <= 1'b0;
      rd_ok_q        <= 1'b0;
    end else begin
      state_q        <= state_d;
      vertex_count_q <= vertex_count_d;
      lim_q          <= lim_d;
      row_q          <= row_d;
      col_q          <= col_d;
      k_q            <= k_d;
      pcol_q         <= pcol_d;
      rd_pend_q      <= rd_pend_d;
      rd_ok_q        <= rd_ok_d;
    end
  end

  // The held (i,k) entry is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    ik_q <= ik_d;
  end

  // Matrix memory: one write port, two reads with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      matrix_mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= matrix_mem[addr_a];
    rd_b_q <= matrix_mem[addr_b];
  end

  assign cfg_ready_o    = 1'b1;
  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rd_pend_q;
  assign distance_o     = rd_ok_q ? rd_b_q : DIST_INF;

  // Every accepted read gives its result strobe in the very next cycle.
  `include "all_pairs_shortest_path_core_assert.svh"

  `APSP_ASSERT_NEXT(a_read_result, accept && (action_i == ACT_READ), result_valid_o, "read result missing")
  `APSP_ASSERT_NOW(a_relax_lowers, mem_we && (state_q == S_SWEEP), mem_wd < rd_b_q, "relaxation raised an entry")
  `APSP_ASSERT_NOW(a_sweep_bounds, state_q == S_SWEEP, (col_q <= lim_q) && (32'(pcol_q) < 32'(lim_q)), "column out of range")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// All-pairs shortest path core testbench
// Drives clear, write, compute and read commands, with vertex count changes
// between phases. A behavioral copy of the distance matrix is updated at each
// command transfer, and every read result is checked against it in order.
// ----------------------------------------------------------------------------

module tb_top;
  import apsp_pkg::*;

  localparam int MAX_V = 256;

  typedef struct {
    action_e                act;
    logic [VERTEX_W-1:0]    src;
    logic [VERTEX_W-1:0]    dst;
    logic [DIST_W-1:0]      weight;
  } command_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_data_i;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          action_i;
  logic [VERTEX_W-1:0] source_vertex_i;
  logic [VERTEX_W-1:0] target_vertex_i;
  logic [DIST_W-1:0]   edge_weight_i;
  logic                result_valid_o;
  logic [DIST_W-1:0]   distance_o;

  all_pairs_shortest_path_core #(
    .MAX_VERTICES(MAX_V)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .source_vertex_i(source_vertex_i),
    .target_vertex_i(target_vertex_i),
    .edge_weight_i  (edge_weight_i),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o)
  );

  // Behavioral copy of the block: the full matrix and the vertex count register.
  logic [DIST_W-1:0]  dist_model [MAX_V][MAX_V];
  logic [COUNT_W-1:0] model_count;

  command_t          cmd_queue[$];
  logic [DIST_W-1:0] expected_distance[$];

  // Set by the driver when it puts a command on the port, cleared by the
  // monitor at the edge where that command transfers.
  bit cmd_in_flight = 1'b0;
  int gap_left      = 0;
  int burst_left    = 0;
  int tail_cycles   = 0;
  bit failed        = 1'b0;
  bit counting      = 1'b0;
  int random_items  = 0;
  int large_phases  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The slowest legal run is dominated by the two 256-vertex clear passes and
  // the compute commands of the medium phases; this is many times over that.
  initial begin
    #40000000;
    $display("tb_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Matrix model
  // --------------------------------------------------------------------------

  // The vertex count saturates at the matrix size.
  function automatic int active_count();
    return (model_count > MAX_V) ? MAX_V : int'(model_count);
  endfunction

  task automatic clear_square(input int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        dist_model[i][j] = (i == j) ? '0 : DIST_INF;
  endtask

  // Floyd-Warshall in k, i, j order. The sum is one bit wider so that two
  // entries near the unreachable value never wrap.
  task automatic relax_square(input int n);
    logic [DIST_W:0]   via;
    logic [DIST_W-1:0] ik;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++) begin
        ik = dist_model[i][k];
        for (int j = 0; j < n; j++) begin
          via = {1'b0, ik} + {1'b0, dist_model[k][j]};
          if (via < {1'b0, dist_model[i][j]})
            dist_model[i][j] = via[DIST_W-1:0];
        end
      end
  endtask

  // Applies one transferred command to the model. Reads queue the distance the
  // block must return; an index outside the active square reads as unreachable.
  task automatic apply_command(input command_t c);
    int n;
    n = active_count();
    tail_cycles = 2;
    case (c.act)
      ACT_CLEAR: begin
        clear_square(n);
        tail_cycles = n * n + 2;
      end
      ACT_WRITE: begin
        dist_model[c.src][c.dst] = c.weight;
      end
      ACT_COMPUTE: begin
        relax_square(n);
        tail_cycles = n * n * (n + 2) + 2;
      end
      ACT_READ: begin
        if (c.src < n && c.dst < n)
          expected_distance.push_back(dist_model[c.src][c.dst]);
        else
          expected_distance.push_back(DIST_INF);
      end
      default: ;
    endcase
  endtask

  // Sender idling: mostly back to back or short gaps, now and then a long
  // one, and occasional bursts with no gaps at all.
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A command stays on the port
  // while busy is high, so commands that arrive during a clear or compute pass
  // press against the end of it.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    command_t c;
    if (rst_ni && !cmd_in_flight) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        c = cmd_queue.pop_front();
        action_i        <= c.act;
        source_vertex_i <= c.src;
        target_vertex_i <= c.dst;
        edge_weight_i   <= c.weight;
        start_i         <= 1'b1;
        cmd_in_flight = 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the command of the same edge is
  // applied, since a read result always comes in the cycle after its transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    command_t         c;
    logic [DIST_W-1:0] want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_distance.size() == 0) begin
          $display("%0t: unexpected read result, distance %0d", $time, distance_o);
          failed = 1'b1;
        end else begin
          want = expected_distance.pop_front();
          if (distance_o !== want) begin
            $display("%0t: distance mismatch, expected %0d, actual %0d",
                     $time, want, distance_o);
            failed = 1'b1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o)
        model_count = cfg_data_i;
      if (start_i && !busy_o) begin
        c.act    = action_e'(action_i);
        c.src    = source_vertex_i;
        c.dst    = target_vertex_i;
        c.weight = edge_weight_i;
        apply_command(c);
        cmd_in_flight = 1'b0;
        gap_left = next_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_command(input action_e act, input int src, input int dst,
                               input logic [DIST_W-1:0] w);
    command_t c;
    c.act    = act;
    c.src    = VERTEX_W'(src);
    c.dst    = VERTEX_W'(dst);
    c.weight = w;
    cmd_queue.push_back(c);
    if (counting)
      random_items++;
  endtask

  // Mostly small weights so that real shortest paths form, plus the extremes,
  // values around half of the unreachable distance whose sums land near it,
  // and fully random words.
  function automatic logic [DIST_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 11);
    if (r < 7)   return DIST_W'($urandom_range(0, 20));
    if (r == 7)  return '0;
    if (r == 8)  return DIST_INF;
    if (r == 9)  return DIST_W'(30'h1FFF_FFCE + $urandom_range(0, 100));
    if (r == 10) return DIST_W'(DIST_INF - $urandom_range(0, 20));
    return DIST_W'($urandom());
  endfunction

  // Mostly inside the active square, some on its border, some anywhere.
  function automatic int pick_vertex(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, n - 1);
    if (r < 90) return (n > 255) ? 255 : $urandom_range(n - 1, n);
    return $urandom_range(0, 255);
  endfunction

  task automatic noise_command(input int n);
    queue_command(action_e'($urandom_range(0, 3)), pick_vertex(n), pick_vertex(n),
                  pick_weight());
  endtask

  // Waits for every queued command to transfer and every read to return, then
  // lets the latency of the last command run out and waits for busy to drop.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || cmd_in_flight || expected_distance.size() != 0)
      @(negedge clk_i);
    repeat (tail_cycles + 2) @(negedge clk_i);
    while (busy_o !== 1'b0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(input int unsigned value);
    @(negedge clk_i);
    cfg_data_i  <= COUNT_W'(value);
    cfg_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One graph: usually a fresh clear, a random edge set, a compute (sometimes
  // two, which must change nothing) and reads of the result, with a little
  // noise mixed in. Skipping the clear builds on whatever the matrix held.
  task automatic graph_episode(input int n);
    int edges;
    int reads;
    int limit;
    if ($urandom_range(0, 9) != 0)
      queue_command(ACT_CLEAR, 0, 0, '0);
    edges = $urandom_range(0, 3 * n);
    repeat (edges) begin
      if ($urandom_range(0, 9) == 0)
        noise_command(n);
      else
        queue_command(ACT_WRITE, pick_vertex(n), pick_vertex(n), pick_weight());
    end
    if ($urandom_range(0, 9) != 0)
      queue_command(ACT_COMPUTE, 0, 0, '0);
    if ($urandom_range(0, 4) == 0)
      queue_command(ACT_COMPUTE, 0, 0, '0);
    limit = (n * n + 3 > 40) ? 40 : n * n + 3;
    reads = $urandom_range(1, limit);
    repeat (reads) begin
      if ($urandom_range(0, 19) == 0)
        noise_command(n);
      else
        queue_command(ACT_READ, pick_vertex(n), pick_vertex(n), pick_weight());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int n;
    int src;
    int dst;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    action_i        = ACT_CLEAR;
    source_vertex_i = '0;
    target_vertex_i = '0;
    edge_weight_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    model_count     = COUNT_RESET;
    clear_square(MAX_V);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its whole matrix after reset with busy high.
    wait_idle();

    // Directed part at the reset count of 256: the corners of the matrix,
    // a write to a pair that a full clear then wipes.
    queue_command(ACT_READ, 0, 0, '0);
    queue_command(ACT_READ, 0, 255, '0);
    queue_command(ACT_WRITE, 255, 0, '0);
    queue_command(ACT_WRITE, 0, 255, DIST_INF);
    queue_command(ACT_WRITE, 7, 9, 30'h2AAA_AAAA);
    queue_command(ACT_READ, 255, 0, '0);
    queue_command(ACT_READ, 7, 9, '0);
    queue_command(ACT_CLEAR, 0, 0, '0);
    queue_command(ACT_READ, 7, 9, '0);
    wait_idle();

    // A count of zero: clear and compute do nothing, reads are unreachable,
    // but a write still lands in the matrix.
    set_vertex_count(0);
    queue_command(ACT_WRITE, 1, 2, DIST_W'(5));
    queue_command(ACT_CLEAR, 0, 0, '0);
    queue_command(ACT_COMPUTE, 0, 0, '0);
    queue_command(ACT_READ, 1, 2, '0);
    queue_command(ACT_READ, 0, 0, '0);
    wait_idle();

    // A count above the matrix size saturates, so the earlier write shows.
    set_vertex_count(511);
    queue_command(ACT_READ, 1, 2, '0);
    wait_idle();

    // A single vertex: compute is trivial and column 1 is outside.
    set_vertex_count(1);
    queue_command(ACT_COMPUTE, 0, 0, '0);
    queue_command(ACT_READ, 0, 0, '0);
    queue_command(ACT_READ, 0, 1, '0);
    wait_idle();

    // Weights at and near the unreachable distance: sums past it must not
    // replace an entry, while a path nine below it must be found.
    set_vertex_count(4);
    queue_command(ACT_WRITE, 0, 1, DIST_INF);
    queue_command(ACT_WRITE, 1, 3, DIST_INF);
    queue_command(ACT_WRITE, 0, 2, DIST_INF - DIST_W'(10));
    queue_command(ACT_WRITE, 2, 3, DIST_W'(1));
    queue_command(ACT_COMPUTE, 0, 0, '0);
    queue_command(ACT_READ, 0, 3, '0);
    queue_command(ACT_READ, 1, 3, '0);
    wait_idle();

    // Random phases, each with its own vertex count.
    counting = 1'b1;
    while (random_items < 1500) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        set_vertex_count(0);
        repeat (10) noise_command(MAX_V);
      end else if (r < 10 && large_phases < 2) begin
        // Large counts: only writes and reads, since a compute pass at these counts
        // is too long to simulate. About half of the writes are read straight back.
        large_phases++;
        case ($urandom_range(0, 2))
          0:       set_vertex_count(256);
          1:       set_vertex_count(511);
          default: set_vertex_count($urandom_range(200, 511));
        endcase
        repeat (60) begin
          src = $urandom_range(0, 255);
          dst = $urandom_range(0, 255);
          if ($urandom_range(0, 1) == 0) begin
            queue_command(ACT_WRITE, src, dst, pick_weight());
            if ($urandom_range(0, 1) == 0)
              queue_command(ACT_READ, src, dst, '0);
          end else begin
            queue_command(ACT_READ, src, dst, pick_weight());
          end
        end
      end else if (r < 22) begin
        n = $urandom_range(11, 18);
        set_vertex_count(n);
        graph_episode(n);
      end else begin
        n = $urandom_range(1, 10);
        set_vertex_count(n);
        repeat ($urandom_range(1, 3)) graph_episode(n);
      end
      wait_idle();
    end

    repeat (20) @(negedge clk_i);
    if (!failed)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
